// ===== hw/rtl/itfp_pkg.sv =====
package itfp_pkg;

   // Field header phases.
   localparam logic [1:0] PH_TYPE   = 2'd0;
   localparam logic [1:0] PH_LEN_HI = 2'd1;
   localparam logic [1:0] PH_LEN_LO = 2'd2;
   localparam logic [1:0] PH_DATA   = 2'd3;

   // Field types of interest.
   localparam logic [4:0] TYPE_HASH   = 5'd1;
   localparam logic [4:0] TYPE_ROUTE  = 5'd3;
   localparam logic [4:0] TYPE_EXPIRY = 5'd6;
   localparam logic [4:0] TYPE_CLTV   = 5'd24;

   // Field geometry.
   localparam logic [9:0] HASH_SYMBOLS      = 10'd52;
   localparam logic [9:0] HASH_BYTES        = 10'd32;
   localparam logic [9:0] ROUTE_ENTRY_BYTES = 10'd51;
   localparam logic [9:0] NODE_ID_BYTES     = 10'd33;
   localparam logic [9:0] MAX_VALUE_SYMBOLS = 10'd6;
   localparam logic [9:0] BYTE_COUNT_MAX    = 10'd1023;
   localparam logic [3:0] ENTRY_MAX         = 4'd15;

   // Route entry byte positions that close a value.
   localparam logic [9:0] POS_CHANNEL  = 10'd40;
   localparam logic [9:0] POS_FEE_BASE = 10'd44;
   localparam logic [9:0] POS_FEE_PROP = 10'd48;
   localparam logic [9:0] POS_DELTA    = 10'd50;

   // Result kinds.
   localparam logic [3:0] KIND_HASH     = 4'd0;
   localparam logic [3:0] KIND_EXPIRY   = 4'd1;
   localparam logic [3:0] KIND_CLTV     = 4'd2;
   localparam logic [3:0] KIND_NODE     = 4'd3;
   localparam logic [3:0] KIND_CHANNEL  = 4'd4;
   localparam logic [3:0] KIND_FEE_BASE = 4'd5;
   localparam logic [3:0] KIND_FEE_PROP = 4'd6;
   localparam logic [3:0] KIND_DELTA    = 4'd7;
   localparam logic [3:0] KIND_DONE     = 4'd8;

   // Status codes.
   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_TRUNCATED = 3'd1;
   localparam logic [2:0] ST_TOO_LONG  = 3'd2;
   localparam logic [2:0] ST_ROUTE     = 3'd3;
   localparam logic [2:0] ST_NO_HASH   = 3'd4;

   // Configuration register indexes and reset values.
   localparam logic CSR_DEFAULT_EXPIRY = 1'b0;
   localparam logic CSR_DEFAULT_CLTV   = 1'b1;
   localparam logic [31:0] DEFAULT_EXPIRY_RESET = 32'd3600;
   localparam logic [31:0] DEFAULT_CLTV_RESET   = 32'd9;

   // Most results one transaction can cause.
   localparam int MAX_RESULTS = 5;

   typedef struct packed {
      logic [4:0] symbol;
      logic       no_data;
      logic       last;
   } req_type;

   typedef struct packed {
      logic [3:0]  kind;
      logic [3:0]  entry;
      logic [5:0]  byte_index;
      logic [63:0] value;
      logic [2:0]  status;
      logic        last_result;
   } rsp_type;

endpackage

// ===== hw/rtl/invoice_tagged_field_parser_unit.sv =====
// Timing: the first result of a transaction is offered in the cycle after it is accepted.
// Throughput: one input transaction per cycle while each causes at most one result and the
// receiver does not stall; a transaction causing n results holds the result register until all n are taken.
// Reset: synchronous, active high; clears the parse state and loads the default expiry
// (3600) and default minimum cltv (9).
module invoice_tagged_field_parser_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  itfp_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output itfp_pkg::rsp_type rsp_data,
   input  logic              csr_we,
   input  logic              csr_index,
   input  logic [31:0]       csr_wdata
);
   import itfp_pkg::*;

   // Parse state.
   logic [1:0]  phase_ff, phase_in;
   logic [4:0]  ftype_ff, ftype_in;
   logic [9:0]  len_ff, len_in;
   logic [9:0]  rem_ff, rem_in;
   logic [11:0] bbuf_ff, bbuf_in;
   logic [3:0]  bheld_ff, bheld_in;
   logic [9:0]  bcnt_ff, bcnt_in;
   logic [3:0]  rent_ff, rent_in;
   logic [63:0] acc_ff, acc_in;
   logic [31:0] expiry_ff, expiry_in;
   logic [31:0] cltv_ff, cltv_in;
   logic        rseen_ff, rseen_in;
   logic        hnz_ff, hnz_in;
   logic [2:0]  err_ff, err_in;
   logic [31:0] dexp_ff;
   logic [31:0] dcltv_ff;

   // Result group buffer.
   rsp_type     grp_ff [MAX_RESULTS];
   rsp_type     grp_in [MAX_RESULTS];
   logic [2:0]  cnt_ff, cnt_in;
   logic [2:0]  idx_ff;

   logic accept;
   logic take;
   logic fin;
   logic busy;

   // Handshake: a new transaction enters when the buffer is empty or drains this cycle.
   assign busy      = (cnt_ff != 3'd0);
   assign rsp_valid = busy;
   assign rsp_data  = grp_ff[idx_ff];
   assign take      = rsp_valid && !rsp_stall;
   assign fin       = take && (idx_ff == cnt_ff - 3'd1);
   assign req_stall = busy && !fin;
   assign accept    = req_valid && !req_stall;

   // One symbol through the field parser, producing the result group.
   always_comb begin
      logic        route_act;
      logic        value_act;
      logic        hash_act;
      logic        do_end;
      logic [7:0]  b;
      logic [1:0]  rbv;
      logic [7:0]  rbb [2];
      logic [9:0]  pos;
      logic [3:0]  kd;
      logic [2:0]  n;

      phase_in  = phase_ff;
      ftype_in  = ftype_ff;
      len_in    = len_ff;
      rem_in    = rem_ff;
      bbuf_in   = bbuf_ff;
      bheld_in  = bheld_ff;
      bcnt_in   = bcnt_ff;
      rent_in   = rent_ff;
      acc_in    = acc_ff;
      expiry_in = expiry_ff;
      cltv_in   = cltv_ff;
      rseen_in  = rseen_ff;
      hnz_in    = hnz_ff;
      err_in    = err_ff;
      route_act = 1'b0;
      value_act = 1'b0;
      hash_act  = 1'b0;
      do_end    = 1'b0;
      b         = 8'd0;
      rbv       = 2'b00;
      rbb[0]    = 8'd0;
      rbb[1]    = 8'd0;
      pos       = 10'd0;
      kd        = KIND_CHANNEL;
      n         = 3'd0;
      for (int i = 0; i < MAX_RESULTS; i++) begin
         grp_in[i] = '0;
      end

      // Symbol handling, skipped for an empty item or once an error has been seen.
      if (!req_data.no_data && err_ff == ST_OK) begin
         unique case (phase_ff)
            PH_TYPE: begin
               ftype_in = req_data.symbol;
               phase_in = PH_LEN_HI;
            end
            PH_LEN_HI: begin
               len_in   = {req_data.symbol, 5'd0};
               phase_in = PH_LEN_LO;
            end
            PH_LEN_LO: begin
               len_in   = len_ff | {5'd0, req_data.symbol};
               rem_in   = len_in;
               bcnt_in  = 10'd0;
               bbuf_in  = 12'd0;
               bheld_in = 4'd0;
               acc_in   = 64'd0;
               if (ftype_in == TYPE_HASH && len_in == HASH_SYMBOLS) begin
                  hnz_in = 1'b0;
               end
               if ((ftype_in == TYPE_EXPIRY || ftype_in == TYPE_CLTV) &&
                   len_in > MAX_VALUE_SYMBOLS) begin
                  err_in = ST_TOO_LONG;
               end else if (ftype_in == TYPE_ROUTE && !rseen_in && len_in == 10'd0) begin
                  err_in = ST_ROUTE;
               end else if (len_in == 10'd0) begin
                  do_end = 1'b1;
               end else begin
                  phase_in = PH_DATA;
               end
            end
            default: begin
               value_act = (ftype_in == TYPE_EXPIRY || ftype_in == TYPE_CLTV);
               hash_act  = (ftype_in == TYPE_HASH && len_in == HASH_SYMBOLS);
               route_act = (ftype_in == TYPE_ROUTE && !rseen_in);
               if (value_act) begin
                  acc_in = {acc_in[58:0], req_data.symbol};
               end else if (hash_act || route_act) begin
                  bbuf_in  = {bbuf_in[6:0], req_data.symbol};
                  bheld_in = bheld_in + 4'd5;
                  if (bheld_in >= 4'd8) begin
                     b        = 8'(bbuf_in >> (bheld_in - 4'd8));
                     bheld_in = bheld_in - 4'd8;
                     bbuf_in  = bbuf_in & ((12'd1 << bheld_in) - 12'd1);
                     if (hash_act) begin
                        if (bcnt_in < HASH_BYTES) begin
                           grp_in[n] = '{KIND_HASH, 4'd0, bcnt_in[5:0], {56'd0, b},
                                         ST_OK, 1'b0};
                           n = n + 3'd1;
                           if (b != 8'd0) begin
                              hnz_in = 1'b1;
                           end
                        end
                        if (bcnt_in < BYTE_COUNT_MAX) begin
                           bcnt_in = bcnt_in + 10'd1;
                        end
                     end else begin
                        rbv[0] = 1'b1;
                        rbb[0] = b;
                     end
                  end
               end
               rem_in = rem_in - 10'd1;
               if (rem_in == 10'd0) begin
                  do_end = 1'b1;
               end
            end
         endcase
      end

      value_act = (ftype_in == TYPE_EXPIRY || ftype_in == TYPE_CLTV);
      route_act = (ftype_in == TYPE_ROUTE && !rseen_in);

      // A partial route byte at field end is padded with zero bits.
      if (do_end && !value_act && route_act && bheld_in != 4'd0 && bheld_in < 4'd8) begin
         rbv[1] = 1'b1;
         rbb[1] = 8'(bbuf_in << (4'd8 - bheld_in));
      end

      // Route bytes: node id bytes, then the big-endian entry values.
      for (int k = 0; k < 2; k++) begin
         if (rbv[k]) begin
            pos = bcnt_in - 10'({6'd0, rent_in} * ROUTE_ENTRY_BYTES);
            if (pos < NODE_ID_BYTES) begin
               grp_in[n] = '{KIND_NODE, rent_in, pos[5:0], {56'd0, rbb[k]}, ST_OK, 1'b0};
               n = n + 3'd1;
            end else begin
               acc_in = {acc_in[55:0], rbb[k]};
               if (pos == POS_CHANNEL || pos == POS_FEE_BASE || pos == POS_FEE_PROP ||
                   pos == POS_DELTA) begin
                  priority if (pos == POS_CHANNEL) begin
                     kd = KIND_CHANNEL;
                  end else if (pos == POS_FEE_BASE) begin
                     kd = KIND_FEE_BASE;
                  end else if (pos == POS_FEE_PROP) begin
                     kd = KIND_FEE_PROP;
                  end else begin
                     kd = KIND_DELTA;
                  end
                  grp_in[n] = '{kd, rent_in, 6'd0, acc_in, ST_OK, 1'b0};
                  n = n + 3'd1;
                  acc_in = 64'd0;
                  if (pos == POS_DELTA && rent_in < ENTRY_MAX) begin
                     rent_in = rent_in + 4'd1;
                  end
               end
            end
            if (bcnt_in < BYTE_COUNT_MAX) begin
               bcnt_in = bcnt_in + 10'd1;
            end
         end
      end

      // Field end: report a value field, or check the route length.
      if (do_end) begin
         if (value_act) begin
            if (ftype_in == TYPE_EXPIRY) begin
               expiry_in = acc_in[31:0];
               grp_in[n] = '{KIND_EXPIRY, 4'd0, 6'd0, {32'd0, acc_in[31:0]}, ST_OK, 1'b0};
            end else begin
               cltv_in   = acc_in[31:0];
               grp_in[n] = '{KIND_CLTV, 4'd0, 6'd0, {32'd0, acc_in[31:0]}, ST_OK, 1'b0};
            end
            n = n + 3'd1;
         end else if (route_act) begin
            if (bcnt_in < ROUTE_ENTRY_BYTES) begin
               err_in = ST_ROUTE;
            end else begin
               rseen_in = 1'b1;
            end
         end
         bbuf_in  = 12'd0;
         bheld_in = 4'd0;
         phase_in = PH_TYPE;
      end

      // Section end: final values and status, then a fresh section.
      if (req_data.last) begin
         if (err_in == ST_OK && phase_in != PH_TYPE) begin
            err_in = ST_TRUNCATED;
         end
         if (err_in == ST_OK && !hnz_in) begin
            err_in = ST_NO_HASH;
         end
         grp_in[n] = '{KIND_EXPIRY, 4'd0, 6'd0, {32'd0, expiry_in}, ST_OK, 1'b0};
         n = n + 3'd1;
         grp_in[n] = '{KIND_CLTV, 4'd0, 6'd0, {32'd0, cltv_in}, ST_OK, 1'b0};
         n = n + 3'd1;
         grp_in[n] = '{KIND_DONE, 4'd0, 6'd0, 64'd0, err_in, 1'b0};
         n = n + 3'd1;
         phase_in  = PH_TYPE;
         ftype_in  = 5'd0;
         len_in    = 10'd0;
         rem_in    = 10'd0;
         bbuf_in   = 12'd0;
         bheld_in  = 4'd0;
         bcnt_in   = 10'd0;
         rent_in   = 4'd0;
         acc_in    = 64'd0;
         expiry_in = dexp_ff;
         cltv_in   = dcltv_ff;
         rseen_in  = 1'b0;
         hnz_in    = 1'b0;
         err_in    = ST_OK;
      end

      if (n != 3'd0) begin
         grp_in[n - 3'd1].last_result = 1'b1;
      end
      cnt_in = n;
   end

   // Parse state and configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_TYPE;
         ftype_ff  <= 5'd0;
         len_ff    <= 10'd0;
         rem_ff    <= 10'd0;
         bbuf_ff   <= 12'd0;
         bheld_ff  <= 4'd0;
         bcnt_ff   <= 10'd0;
         rent_ff   <= 4'd0;
         acc_ff    <= 64'd0;
         expiry_ff <= DEFAULT_EXPIRY_RESET;
         cltv_ff   <= DEFAULT_CLTV_RESET;
         rseen_ff  <= 1'b0;
         hnz_ff    <= 1'b0;
         err_ff    <= ST_OK;
         dexp_ff   <= DEFAULT_EXPIRY_RESET;
         dcltv_ff  <= DEFAULT_CLTV_RESET;
      end else begin
         if (accept) begin
            phase_ff  <= phase_in;
            ftype_ff  <= ftype_in;
            len_ff    <= len_in;
            rem_ff    <= rem_in;
            bbuf_ff   <= bbuf_in;
            bheld_ff  <= bheld_in;
            bcnt_ff   <= bcnt_in;
            rent_ff   <= rent_in;
            acc_ff    <= acc_in;
            expiry_ff <= expiry_in;
            cltv_ff   <= cltv_in;
            rseen_ff  <= rseen_in;
            hnz_ff    <= hnz_in;
            err_ff    <= err_in;
         end
         if (csr_we) begin
            if (csr_index == CSR_DEFAULT_EXPIRY) begin
               dexp_ff   <= csr_wdata;
               expiry_ff <= csr_wdata;
            end else begin
               dcltv_ff <= csr_wdata;
               cltv_ff  <= csr_wdata;
            end
         end
      end
   end

   // Result group buffer: filled on acceptance, drained one result per transaction.
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 3'd0;
         idx_ff <= 3'd0;
      end else if (accept) begin
         cnt_ff <= cnt_in;
         idx_ff <= 3'd0;
      end else if (fin) begin
         cnt_ff <= 3'd0;
         idx_ff <= 3'd0;
      end else if (take) begin
         idx_ff <= idx_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         grp_ff <= grp_in;
      end
   end

   // The read pointer stays inside the filled part of the group.
   assert property (@(posedge clock) disable iff (reset)
      busy |-> (idx_ff < cnt_ff && cnt_ff <= 3'(MAX_RESULTS)))
      else $error("result pointer outside group");

   // A done result always closes its group.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.kind == KIND_DONE) |-> rsp_data.last_result)
      else $error("done result not last in group");

   // An error holds until the section ends.
   assert property (@(posedge clock) disable iff (reset)
      (err_ff != ST_OK && !(accept && req_data.last)) |=> (err_ff == $past(err_ff)))
      else $error("error code changed inside section");

   // Only a status result carries a nonzero status.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.kind != KIND_DONE) |-> (rsp_data.status == ST_OK))
      else $error("status on a non-done result");

endmodule

// ===== tb/invoice_tagged_field_parser_unit_tb.sv =====
module invoice_tagged_field_parser_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import itfp_pkg::*;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;
   logic    csr_we = 1'b0;
   logic    csr_index = 1'b0;
   logic [31:0] csr_wdata = '0;

   invoice_tagged_field_parser_unit dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #6 clock = ~clock;

   // Directed table row: a section end with defaults can carry its results typed in.
   typedef struct {
      req_type     item;
      bit          typed;
      logic [31:0] exp_expiry;
      logic [31:0] exp_cltv;
      logic [2:0]  exp_status;
   } table_row_type;

   // Parser state mirrored by the predictor.
   logic [1:0]  prs_phase;
   logic [4:0]  prs_type;
   logic [9:0]  prs_len;
   logic [9:0]  prs_left;
   logic [11:0] prs_buf;
   int          prs_nbits;
   logic [9:0]  prs_bytes;
   logic [3:0]  prs_entries;
   logic [63:0] prs_acc;
   logic [31:0] prs_expiry;
   logic [31:0] prs_cltv;
   bit          prs_route_done;
   bit          prs_hash_nz;
   logic [2:0]  prs_err;
   logic [31:0] cfg_expiry = DEFAULT_EXPIRY_RESET;
   logic [31:0] cfg_cltv = DEFAULT_CLTV_RESET;

   rsp_type       step_results[$];
   rsp_type       pending_results[$];
   req_type       section_items[$];
   table_row_type directed_rows[$];
   int        mismatches = 0;
   int        send_idle_pct = 0;
   int        recv_stall_pct = 0;
   int        items_sent;

   function automatic void emit(logic [3:0] kind, logic [3:0] entry, logic [5:0] idx,
                                logic [63:0] value, logic [2:0] status);
      rsp_type r;
      if (step_results.size() < 6) begin
         r.kind = kind;
         r.entry = entry;
         r.byte_index = idx;
         r.value = value;
         r.status = status;
         r.last_result = 1'b0;
         step_results.push_back(r);
      end
   endfunction

   function automatic void clear_section();
      prs_phase = PH_TYPE;
      prs_type = '0;
      prs_len = '0;
      prs_left = '0;
      prs_buf = '0;
      prs_nbits = 0;
      prs_bytes = '0;
      prs_entries = '0;
      prs_acc = '0;
      prs_expiry = cfg_expiry;
      prs_cltv = cfg_cltv;
      prs_route_done = 0;
      prs_hash_nz = 0;
      prs_err = ST_OK;
   endfunction

   function automatic bit route_on();
      return prs_type == TYPE_ROUTE && !prs_route_done;
   endfunction

   function automatic bit hash_on();
      return prs_type == TYPE_HASH && prs_len == HASH_SYMBOLS;
   endfunction

   function automatic bit value_on();
      return prs_type == TYPE_EXPIRY || prs_type == TYPE_CLTV;
   endfunction

   // One route byte: node id bytes go out directly, later bytes build values.
   function automatic void route_byte(logic [7:0] b);
      logic [9:0] pos;
      pos = prs_bytes - 10'(prs_entries * ROUTE_ENTRY_BYTES);
      if (pos < NODE_ID_BYTES) begin
         emit(KIND_NODE, prs_entries, pos[5:0], 64'(b), ST_OK);
      end else begin
         prs_acc = {prs_acc[55:0], b};
         if (pos == POS_CHANNEL || pos == POS_FEE_BASE || pos == POS_FEE_PROP ||
             pos == POS_DELTA) begin
            emit(pos == POS_CHANNEL ? KIND_CHANNEL : pos == POS_FEE_BASE ? KIND_FEE_BASE :
                 pos == POS_FEE_PROP ? KIND_FEE_PROP : KIND_DELTA,
                 prs_entries, '0, prs_acc, ST_OK);
            prs_acc = '0;
            if (pos == POS_DELTA && prs_entries < ENTRY_MAX) prs_entries++;
         end
      end
      if (prs_bytes < BYTE_COUNT_MAX) prs_bytes++;
   endfunction

   function automatic void close_field();
      if (value_on()) begin
         if (prs_type == TYPE_EXPIRY) begin
            prs_expiry = prs_acc[31:0];
            emit(KIND_EXPIRY, '0, '0, 64'(prs_acc[31:0]), ST_OK);
         end else begin
            prs_cltv = prs_acc[31:0];
            emit(KIND_CLTV, '0, '0, 64'(prs_acc[31:0]), ST_OK);
         end
      end else if (route_on()) begin
         if (prs_nbits > 0 && prs_nbits < 8)
            route_byte(8'((prs_buf << (8 - prs_nbits)) & 12'hFF));
         if (prs_bytes < ROUTE_ENTRY_BYTES) prs_err = ST_ROUTE;
         else prs_route_done = 1;
      end
      prs_buf = '0;
      prs_nbits = 0;
      prs_phase = PH_TYPE;
   endfunction

   function automatic void take_symbol(logic [4:0] sym);
      logic [7:0] b;
      case (prs_phase)
         PH_TYPE: begin
            prs_type = sym;
            prs_phase = PH_LEN_HI;
         end
         PH_LEN_HI: begin
            prs_len = {sym, 5'd0};
            prs_phase = PH_LEN_LO;
         end
         PH_LEN_LO: begin
            prs_len = prs_len | 10'(sym);
            prs_left = prs_len;
            prs_bytes = '0;
            prs_buf = '0;
            prs_nbits = 0;
            prs_acc = '0;
            if (hash_on()) prs_hash_nz = 0;
            if (value_on() && prs_len > MAX_VALUE_SYMBOLS) begin
               prs_err = ST_TOO_LONG;
            end else if (route_on() && prs_len == 0) begin
               prs_err = ST_ROUTE;
            end else if (prs_left == 0) begin
               close_field();
            end else begin
               prs_phase = PH_DATA;
            end
         end
         default: begin
            if (value_on()) begin
               prs_acc = {prs_acc[58:0], sym};
            end else if (hash_on() || route_on()) begin
               prs_buf = {prs_buf[6:0], sym};
               prs_nbits += 5;
               if (prs_nbits >= 8) begin
                  b = 8'(prs_buf >> (prs_nbits - 8));
                  prs_nbits -= 8;
                  prs_buf &= 12'((1 << prs_nbits) - 1);
                  if (hash_on()) begin
                     if (prs_bytes < HASH_BYTES) begin
                        emit(KIND_HASH, '0, prs_bytes[5:0], 64'(b), ST_OK);
                        if (b != 0) prs_hash_nz = 1;
                     end
                     if (prs_bytes < BYTE_COUNT_MAX) prs_bytes++;
                  end else begin
                     route_byte(b);
                  end
               end
            end
            prs_left = prs_left - 10'd1;
            if (prs_left == 0) close_field();
         end
      endcase
   endfunction

   // Work out the results of one accepted transaction into step_results.
   function automatic void predict_results(req_type it);
      step_results.delete();
      if (!it.no_data && prs_err == ST_OK) take_symbol(it.symbol);
      if (it.last) begin
         if (prs_err == ST_OK && prs_phase != PH_TYPE) prs_err = ST_TRUNCATED;
         if (prs_err == ST_OK && !prs_hash_nz) prs_err = ST_NO_HASH;
         emit(KIND_EXPIRY, '0, '0, 64'(prs_expiry), ST_OK);
         emit(KIND_CLTV, '0, '0, 64'(prs_cltv), ST_OK);
         emit(KIND_DONE, '0, '0, '0, prs_err);
         clear_section();
      end
      if (step_results.size() > 0) step_results[$].last_result = 1'b1;
   endfunction

   // Offer one transaction, starting and ending at a falling edge.
   task automatic send_item(req_type it, bit typed = 0, logic [31:0] e_exp = '0,
                            logic [31:0] e_cltv = '0, logic [2:0] e_st = '0);
      rsp_type r;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= it;
      do @(posedge clock); while (req_stall);
      predict_results(it);
      if (typed) begin
         step_results.delete();
         r = '0;
         r.kind = KIND_EXPIRY;
         r.value = 64'(e_exp);
         step_results.push_back(r);
         r.kind = KIND_CLTV;
         r.value = 64'(e_cltv);
         step_results.push_back(r);
         r.kind = KIND_DONE;
         r.value = '0;
         r.status = e_st;
         r.last_result = 1'b1;
         step_results.push_back(r);
      end
      foreach (step_results[i]) pending_results.push_back(step_results[i]);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic write_csr(logic idx, logic [31:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      if (idx == CSR_DEFAULT_EXPIRY) begin
         cfg_expiry = val;
         prs_expiry = val;
      end else begin
         cfg_cltv = val;
         prs_cltv = val;
      end
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   function automatic req_type mk(logic [4:0] sym, bit nd = 0, bit lst = 0);
      req_type it;
      it.symbol = sym;
      it.no_data = nd;
      it.last = lst;
      return it;
   endfunction

   function automatic void add_row(req_type it, bit typed = 0, logic [2:0] st = ST_OK);
      table_row_type row;
      row.item = it;
      row.typed = typed;
      row.exp_expiry = DEFAULT_EXPIRY_RESET;
      row.exp_cltv = DEFAULT_CLTV_RESET;
      row.exp_status = st;
      directed_rows.push_back(row);
   endfunction

   // Field header followed by the given number of data symbols, random or, with zero_data, all zero.
   function automatic void add_field(logic [4:0] ftype, int len, bit zero_data = 0);
      section_items.push_back(mk(ftype));
      section_items.push_back(mk(5'(len >> 5)));
      section_items.push_back(mk(5'(len)));
      for (int i = 0; i < len; i++)
         section_items.push_back(mk(zero_data ? 5'd0 : 5'($urandom_range(31))));
   endfunction

   // Build one section: mostly well formed, sometimes cut short or pure noise.
   function automatic void build_section();
      int nfields;
      int pick;
      int cut;
      logic [4:0] other;
      section_items.delete();
      if ($urandom_range(9) == 0) begin
         repeat ($urandom_range(1, 10))
            section_items.push_back(mk(5'($urandom_range(31)), 1'($urandom_range(1)),
                                       1'($urandom_range(3) == 0)));
         return;
      end
      nfields = $urandom_range(1, 4);
      for (int f = 0; f < nfields; f++) begin
         pick = $urandom_range(9);
         case (pick)
            0, 1: add_field(TYPE_HASH, 52, $urandom_range(7) == 0);
            2: add_field(TYPE_HASH, $urandom_range(0, 60));
            3: add_field(TYPE_EXPIRY, $urandom_range(9) == 0 ? $urandom_range(7, 9)
                                                             : $urandom_range(0, 6));
            4: add_field(TYPE_CLTV, $urandom_range(9) == 0 ? $urandom_range(7, 9)
                                                           : $urandom_range(0, 6));
            5: begin
               case ($urandom_range(7))
                  0: add_field(TYPE_ROUTE, 0);
                  1: add_field(TYPE_ROUTE, $urandom_range(1, 81));
                  2: add_field(TYPE_ROUTE, 164);
                  default: add_field(TYPE_ROUTE, $urandom_range(82, 90));
               endcase
            end
            default: begin
               do other = 5'($urandom_range(31));
               while (other == TYPE_HASH || other == TYPE_ROUTE || other == TYPE_EXPIRY ||
                      other == TYPE_CLTV);
               add_field(other, $urandom_range(0, 8));
            end
         endcase
      end
      if ($urandom_range(7) == 0) begin
         cut = $urandom_range(0, section_items.size() - 1);
         while (section_items.size() > cut) void'(section_items.pop_back());
      end
      if (section_items.size() > 0 && $urandom_range(1) == 0)
         section_items[$].last = 1'b1;
      else
         section_items.push_back(mk(5'($urandom_range(31)), 1'b1, 1'b1));
   endfunction

   // Result checker against the oldest expectation.
   always @(posedge clock) begin
      rsp_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result transaction: %p", rsp_data);
         end else begin
            e = pending_results.pop_front();
            if (rsp_data.kind !== e.kind || rsp_data.entry !== e.entry ||
                rsp_data.byte_index !== e.byte_index || rsp_data.value !== e.value ||
                rsp_data.status !== e.status || rsp_data.last_result !== e.last_result) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("result mismatch: expected %p, got %p", e, rsp_data);
            end
         end
      end
   end

   // Receiver back-pressure.
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_stall_pct);
   end

   initial begin
      #5_000_000;
      $display("invoice_tagged_field_parser_unit_tb failed");
      $finish;
   end

   initial begin
      int send_pct[4];
      int stall_pct[4];
      logic [31:0] cfg_a[4];
      logic [31:0] cfg_b[4];
      send_pct = '{0, 53, 0, 23};
      stall_pct = '{0, 0, 53, 23};
      cfg_a = '{DEFAULT_EXPIRY_RESET, 32'd0, 32'hFFFF_FFFF, 32'h0};
      cfg_b = '{DEFAULT_CLTV_RESET, 32'd0, 32'hFFFF_FFFF, 32'h0};
      cfg_a[3] = $urandom;
      cfg_b[3] = $urandom;
      clear_section();
      repeat (5) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Empty section after reset: defaults and no hash.
      add_row(mk(5'd31, 1'b1, 1'b1), 1, ST_NO_HASH);
      // Expiry field longer than six symbols.
      add_row(mk(TYPE_EXPIRY));
      add_row(mk(5'd0));
      add_row(mk(5'd7));
      add_row(mk(5'd31));
      add_row(mk(5'd0, 1'b1, 1'b1), 1, ST_TOO_LONG);
      // Section ends inside a field header.
      add_row(mk(5'd5));
      add_row(mk(5'd0, 1'b1, 1'b1), 1, ST_TRUNCATED);
      // Route field of zero length.
      add_row(mk(TYPE_ROUTE));
      add_row(mk(5'd0));
      add_row(mk(5'd0));
      add_row(mk(5'd0, 1'b1, 1'b1), 1, ST_ROUTE);
      // An empty item does nothing; then six-symbol expiry and a cltv field.
      add_row(mk(5'd31, 1'b1, 1'b0));
      add_row(mk(TYPE_EXPIRY));
      add_row(mk(5'd0));
      add_row(mk(5'd6));
      for (int i = 0; i < 6; i++) add_row(mk(5'd31));
      add_row(mk(TYPE_CLTV));
      add_row(mk(5'd0));
      add_row(mk(5'd1));
      add_row(mk(5'd31, 1'b0, 1'b1));
      foreach (directed_rows[i])
         send_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].exp_expiry,
                   directed_rows[i].exp_cltv, directed_rows[i].exp_status);
      wait_drained();

      // Random phases, each with its own register setting and idling pattern.
      for (int p = 0; p < 4; p++) begin
         write_csr(CSR_DEFAULT_EXPIRY, cfg_a[p]);
         write_csr(CSR_DEFAULT_CLTV, cfg_b[p]);
         send_idle_pct = send_pct[p];
         recv_stall_pct = stall_pct[p];
         items_sent = 0;
         while (items_sent < 111) begin
            build_section();
            foreach (section_items[i])
               if (items_sent < 111) send_item(section_items[i]);
         end
         wait_drained();
      end

      recv_stall_pct = 0;
      if (mismatches == 0 && pending_results.size() == 0)
         $display("invoice_tagged_field_parser_unit_tb passed");
      else
         $display("invoice_tagged_field_parser_unit_tb failed");
      $finish;
   end

endmodule

// ===== filelist.f =====
hw/rtl/itfp_pkg.sv
hw/rtl/invoice_tagged_field_parser_unit.sv
tb/invoice_tagged_field_parser_unit_tb.sv
